// File: sv/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated by reset.
`define AST_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, gated by reset.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: sv/lbm_pkg.sv
`default_nettype none
package lbm_pkg;

	localparam int BAR_COUNT    = 6;
	localparam int LEDS_PER_BAR = 38;
	localparam int STAR_LEDS    = 6;
	localparam int BAND_INPUTS  = 6;

	localparam int LED_AW = $clog2(LEDS_PER_BAR);
	localparam int LANE_W = (BAR_COUNT > 1) ? $clog2(BAR_COUNT) : 1;
	localparam int POS_W  = 7;

	localparam logic [23:0] RED_FULL  = 24'hFA0000;
	localparam logic [4:0]  HOLD_BASE = 5'd19;
	localparam logic [5:0]  PAL_LAST  = 6'd37;

	localparam logic [2:0] CFG_ACTIVE_TICKS = 3'd0;
	localparam logic [2:0] CFG_FALL_PERIOD  = 3'd1;
	localparam logic [2:0] CFG_BAR_MARGIN   = 3'd2;
	localparam logic [2:0] CFG_STAR_MARGIN  = 3'd3;
	localparam logic [2:0] CFG_RPT_LIMIT    = 3'd4;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_LOAD  = 2'd1,
		OP_READ  = 2'd2,
		OP_START = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		TS_INIT,
		TS_IDLE,
		TS_WAIT,
		TS_READ
	} top_state_t;

	typedef enum logic [2:0] {
		LS_IDLE,
		LS_WR0,
		LS_WR1,
		LS_SRD,
		LS_SWR,
		LS_CLR
	} lane_state_t;

	typedef struct packed {
		logic load;
		logic tick;
		logic clear;
		logic clr_red;
	} lane_cmd_t;

	typedef struct packed {
		logic [3:0] fall_period;
		logic [3:0] margin;
		logic [1:0] limit;
	} lane_cfg_t;

	function automatic logic [23:0] pal_rgb(input logic [5:0] idx);
		logic [23:0] c;
		case (idx)
			6'd0:  c = {8'd250, 8'd0,   8'd0};
			6'd1:  c = {8'd250, 8'd25,  8'd0};
			6'd2:  c = {8'd250, 8'd50,  8'd0};
			6'd3:  c = {8'd250, 8'd75,  8'd0};
			6'd4:  c = {8'd250, 8'd100, 8'd0};
			6'd5:  c = {8'd250, 8'd150, 8'd0};
			6'd6:  c = {8'd250, 8'd200, 8'd0};
			6'd7:  c = {8'd250, 8'd250, 8'd0};
			6'd8:  c = {8'd200, 8'd250, 8'd0};
			6'd9:  c = {8'd150, 8'd250, 8'd0};
			6'd10: c = {8'd100, 8'd250, 8'd0};
			6'd11: c = {8'd50,  8'd250, 8'd0};
			6'd12: c = {8'd0,   8'd250, 8'd0};
			6'd13: c = {8'd0,   8'd250, 8'd25};
			6'd14: c = {8'd0,   8'd250, 8'd50};
			6'd15: c = {8'd0,   8'd250, 8'd75};
			6'd16: c = {8'd0,   8'd250, 8'd100};
			6'd17: c = {8'd0,   8'd250, 8'd150};
			6'd18: c = {8'd0,   8'd250, 8'd200};
			6'd19: c = {8'd0,   8'd250, 8'd250};
			6'd20: c = {8'd0,   8'd200, 8'd250};
			6'd21: c = {8'd0,   8'd150, 8'd250};
			6'd22: c = {8'd0,   8'd100, 8'd250};
			6'd23: c = {8'd0,   8'd50,  8'd250};
			6'd24: c = {8'd0,   8'd0,   8'd250};
			6'd25: c = {8'd50,  8'd0,   8'd250};
			6'd26: c = {8'd100, 8'd0,   8'd250};
			6'd27: c = {8'd125, 8'd0,   8'd250};
			6'd28: c = {8'd150, 8'd0,   8'd250};
			6'd29: c = {8'd175, 8'd0,   8'd250};
			6'd30: c = {8'd200, 8'd0,   8'd250};
			6'd31: c = {8'd250, 8'd0,   8'd250};
			6'd32: c = {8'd250, 8'd0,   8'd200};
			6'd33: c = {8'd250, 8'd0,   8'd150};
			6'd34: c = {8'd250, 8'd0,   8'd100};
			6'd35: c = {8'd250, 8'd0,   8'd75};
			6'd36: c = {8'd250, 8'd0,   8'd50};
			default: c = {8'd250, 8'd0, 8'd25};
		endcase
		return c;
	endfunction

	// star channels: red takes blue, green takes red, blue takes green
	function automatic logic [23:0] pal_rot(input logic [5:0] idx);
		logic [23:0] c;
		c = pal_rgb(idx);
		return {c[7:0], c[23:16], c[15:8]};
	endfunction

endpackage
`default_nettype wire

// File: sv/lbm_ram.sv
`default_nettype none
module lbm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 38
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: sv/lbm_lane.sv
`default_nettype none
module lbm_lane (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire lbm_pkg::lane_cmd_t        cmd,
	input  wire logic [3:0]                level,
	input  wire lbm_pkg::lane_cfg_t        cfg,
	input  wire logic [lbm_pkg::LED_AW-1:0] rd_addr,
	output logic                           busy,
	output logic [23:0]                    rd_data
);
	localparam logic [lbm_pkg::POS_W-1:0] LAST =
		lbm_pkg::POS_W'(lbm_pkg::LEDS_PER_BAR - 1);
	localparam logic [lbm_pkg::POS_W-1:0] NLED =
		lbm_pkg::POS_W'(lbm_pkg::LEDS_PER_BAR);

	lbm_pkg::lane_state_t state_q, state_d;

	logic [3:0] lvl_q, seen_q;
	logic       rising_q;
	logic [4:0] h_q;
	logic [1:0] rpt_q;
	logic [5:0] peak_q;
	logic [3:0] timer_q;
	logic [lbm_pkg::POS_W-1:0] j_q;
	logic       red_q;
	logic [lbm_pkg::POS_W-1:0] wa0_q, wa1_q;
	logic [23:0] wd0_q, wd1_q;
	logic [1:0] nwr_q;
	logic       shift_q;

	// tick decision
	logic trig, rise, fresh, sh;
	logic [4:0] h_n;
	logic [3:0] seen_n, lvl_n, tmr_n, tmr_inc;
	logic [1:0] rpt_n, nw;
	logic [5:0] peak_n;
	logic [lbm_pkg::POS_W-1:0] a0, a1, top, st;
	logic [23:0] d0, d1;

	always_comb begin
		rise   = rising_q;
		h_n    = h_q;
		seen_n = seen_q;
		lvl_n  = lvl_q;
		rpt_n  = rpt_q;
		peak_n = peak_q;
		fresh  = 1'b0;
		sh     = 1'b0;
		nw     = 2'd0;
		a0     = '0;
		a1     = '0;
		d0     = '0;
		d1     = '0;
		st     = '0;
		top    = {1'b0, h_q, 1'b0} + 7'd2;
		trig   = (lvl_q > seen_q) ||
			((({1'b0, h_q} + {2'b0, cfg.margin}) < {2'b0, lvl_q}) && (rpt_q < cfg.limit));
		if (trig) begin
			rise   = 1'b1;
			rpt_n  = (seen_q == lvl_q) ? rpt_q + 2'd1 : 2'd0;
			seen_n = lvl_q;
		end
		if (rise) begin
			if (h_q < {1'b0, lvl_q}) begin
				h_n = h_q + 5'd1;
				a0  = {1'b0, h_n, 1'b0};
				a1  = a0 | 7'd1;
				d0  = lbm_pkg::pal_rgb(a0[5:0]);
				d1  = lbm_pkg::pal_rgb(a1[5:0]);
				nw  = 2'd2;
			end else begin
				if ({1'b0, peak_q} < top) begin
					a0     = top;
					d0     = lbm_pkg::pal_rgb(top[5:0]);
					nw     = 2'd1;
					peak_n = top[5:0];
					fresh  = 1'b1;
				end
				rise = 1'b0;
			end
		end else if (h_q != 5'd0) begin
			a0  = {1'b0, h_q, 1'b0};
			a1  = a0 | 7'd1;
			nw  = 2'd2;
			h_n = h_q - 5'd1;
		end else begin
			seen_n = '0;
			lvl_n  = '0;
		end
		tmr_inc = timer_q + 4'd1;
		tmr_n   = tmr_inc;
		if (fresh) begin
			tmr_n = '0;
		end else if (tmr_inc >= cfg.fall_period) begin
			tmr_n = '0;
			if (peak_n != 6'd0) begin
				peak_n = peak_n - 6'd1;
			end
			sh = 1'b1;
			st = {1'b0, h_n, 1'b0} + (rise ? 7'd2 : 7'd4);
		end
	end

	// memory port control
	logic                       we;
	logic [lbm_pkg::POS_W-1:0]  wpos;
	logic [23:0]                wdat;
	logic [lbm_pkg::POS_W-1:0]  rpos;
	logic                       shift_more;
	logic [23:0]                ram_q;

	assign shift_more = (j_q + 7'd1) < NLED;

	always_comb begin
		we   = 1'b0;
		wpos = j_q;
		wdat = '0;
		rpos = {1'b0, rd_addr};
		case (state_q)
			lbm_pkg::LS_WR0: begin
				we   = wa0_q < NLED;
				wpos = wa0_q;
				wdat = wd0_q;
			end
			lbm_pkg::LS_WR1: begin
				we   = wa1_q < NLED;
				wpos = wa1_q;
				wdat = wd1_q;
			end
			lbm_pkg::LS_SRD: begin
				rpos = j_q + 7'd1;
				if (!shift_more) begin
					we   = 1'b1;
					wpos = LAST;
				end
			end
			lbm_pkg::LS_SWR: begin
				we   = 1'b1;
				wdat = ram_q;
			end
			lbm_pkg::LS_CLR: begin
				we   = 1'b1;
				wdat = (red_q && j_q < 7'd2) ? lbm_pkg::RED_FULL : 24'd0;
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			lbm_pkg::LS_IDLE: begin
				if (cmd.clear) begin
					state_d = lbm_pkg::LS_CLR;
				end else if (cmd.tick) begin
					if (nw != 2'd0) begin
						state_d = lbm_pkg::LS_WR0;
					end else if (sh) begin
						state_d = lbm_pkg::LS_SRD;
					end
				end
			end
			lbm_pkg::LS_WR0: begin
				if (nwr_q == 2'd2) begin
					state_d = lbm_pkg::LS_WR1;
				end else begin
					state_d = shift_q ? lbm_pkg::LS_SRD : lbm_pkg::LS_IDLE;
				end
			end
			lbm_pkg::LS_WR1: state_d = shift_q ? lbm_pkg::LS_SRD : lbm_pkg::LS_IDLE;
			lbm_pkg::LS_SRD: state_d = shift_more ? lbm_pkg::LS_SWR : lbm_pkg::LS_IDLE;
			lbm_pkg::LS_SWR: state_d = lbm_pkg::LS_SRD;
			lbm_pkg::LS_CLR: state_d = (j_q == LAST) ? lbm_pkg::LS_IDLE : lbm_pkg::LS_CLR;
			default:         state_d = lbm_pkg::LS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= lbm_pkg::LS_CLR;
			lvl_q    <= '0;
			seen_q   <= '0;
			rising_q <= 1'b0;
			h_q      <= '0;
			rpt_q    <= '0;
			peak_q   <= '0;
			timer_q  <= '0;
			j_q      <= '0;
			red_q    <= 1'b0;
			nwr_q    <= '0;
			shift_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				lbm_pkg::LS_IDLE: begin
					if (cmd.load) begin
						lvl_q <= level;
					end
					if (cmd.clear) begin
						h_q   <= '0;
						j_q   <= '0;
						red_q <= cmd.clr_red;
					end else if (cmd.tick) begin
						lvl_q    <= lvl_n;
						seen_q   <= seen_n;
						rising_q <= rise;
						h_q      <= h_n;
						rpt_q    <= rpt_n;
						peak_q   <= peak_n;
						timer_q  <= tmr_n;
						nwr_q    <= nw;
						shift_q  <= sh;
						j_q      <= st;
					end
				end
				lbm_pkg::LS_SWR: j_q <= j_q + 7'd1;
				lbm_pkg::LS_CLR: j_q <= j_q + 7'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lbm_pkg::LS_IDLE && cmd.tick) begin
			wa0_q <= a0;
			wa1_q <= a1;
			wd0_q <= d0;
			wd1_q <= d1;
		end
	end

	lbm_ram #(.WIDTH(24), .DEPTH(lbm_pkg::LEDS_PER_BAR)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (wpos[lbm_pkg::LED_AW-1:0]),
		.wdata (wdat),
		.raddr (rpos[lbm_pkg::LED_AW-1:0]),
		.rdata (ram_q)
	);

	assign busy    = state_q != lbm_pkg::LS_IDLE;
	assign rd_data = ram_q;
endmodule
`default_nettype wire

// File: sv/led_bar_meter_peak_fall_unit.sv
// channel   | handshake          | payload
// ----------+--------------------+---------------------------------------------
// request   | start / busy       | opcode, band_level_0..5, total_level,
//           |                    | group_index, led_index
// result    | done (one cycle)   | red_duty, green_duty, blue_duty, running
// config    | cfg_we             | cfg_index, cfg_data
//
// Load and read results are registered; a read also passes through the registered
// frame memory read. Tick time is set by each lane's shift sweep through its
// frame memory; lanes run together. Start or expiry rewrites the frame memory,
// one memory row per cycle. After reset a clearing pass holds busy high.
// Results cannot be stalled; done pulses once per request.
`default_nettype none
module led_bar_meter_peak_fall_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	output logic             done,
	input  wire logic [1:0]  opcode,
	input  wire logic [3:0]  band_level_0,
	input  wire logic [3:0]  band_level_1,
	input  wire logic [3:0]  band_level_2,
	input  wire logic [3:0]  band_level_3,
	input  wire logic [3:0]  band_level_4,
	input  wire logic [3:0]  band_level_5,
	input  wire logic [5:0]  total_level,
	input  wire logic [2:0]  group_index,
	input  wire logic [5:0]  led_index,
	output logic      [7:0]  red_duty,
	output logic      [7:0]  green_duty,
	output logic      [7:0]  blue_duty,
	output logic             running,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);
	lbm_pkg::top_state_t state_q, state_d;

	logic [15:0] active_q, etime_q;
	logic [3:0]  period_q, bmargin_q;
	logic [5:0]  smargin_q;
	logic [1:0]  limit_q;
	logic        enabled_q;

	logic [5:0]  s_total_q, s_seen_q, s_step_q, s_cnt_q;
	logic [4:0]  s_time_q;
	logic [1:0]  s_rpt_q;
	logic        s_hold_q;
	logic [23:0] star_rgb_q;

	logic                      rd_bar_q, rd_star_q;
	logic [lbm_pkg::LANE_W-1:0] rd_lane_q;
	logic [23:0]               rgb_q;
	logic                      done_q;

	logic acc, lanes_idle, expire;
	logic [15:0] etime_inc;
	lbm_pkg::op_t op;
	lbm_pkg::lane_cmd_t cmd;
	lbm_pkg::lane_cfg_t lcfg;

	logic [lbm_pkg::BAR_COUNT-1:0] lane_busy;
	logic [23:0] lane_rd [lbm_pkg::BAR_COUNT];
	logic [3:0]  band [lbm_pkg::BAND_INPUTS];

	assign band[0] = band_level_0;
	assign band[1] = band_level_1;
	assign band[2] = band_level_2;
	assign band[3] = band_level_3;
	assign band[4] = band_level_4;
	assign band[5] = band_level_5;

	assign op         = lbm_pkg::op_t'(opcode);
	assign acc        = start && (state_q == lbm_pkg::TS_IDLE);
	assign lanes_idle = lane_busy == '0;
	assign etime_inc  = etime_q + 16'd1;
	assign expire     = etime_inc >= active_q;
	assign lcfg       = '{fall_period: period_q, margin: bmargin_q, limit: limit_q};

	always_comb begin
		cmd = '0;
		if (acc) begin
			case (op)
				lbm_pkg::OP_LOAD:  cmd.load = 1'b1;
				lbm_pkg::OP_START: begin
					cmd.clear   = 1'b1;
					cmd.clr_red = 1'b1;
				end
				lbm_pkg::OP_TICK: begin
					if (enabled_q) begin
						cmd.clear   = expire;
						cmd.clr_red = expire;
						cmd.tick    = !expire;
					end
				end
				default: ;
			endcase
		end
	end

	genvar b;
	generate
		for (b = 0; b < lbm_pkg::BAR_COUNT; b++) begin : g_lane
			logic [3:0] lvl;
			if (b < lbm_pkg::BAND_INPUTS) begin : g_in
				assign lvl = band[b];
			end else begin : g_zero
				assign lvl = 4'd0;
			end
			lbm_lane u_lane (
				.clk     (clk),
				.arst_n  (arst_n),
				.cmd     (cmd),
				.level   (lvl),
				.cfg     (lcfg),
				.rd_addr (led_index[lbm_pkg::LED_AW-1:0]),
				.busy    (lane_busy[b]),
				.rd_data (lane_rd[b])
			);
		end
	endgenerate

	// star group step
	logic        s_trig, s_hold_n;
	logic [5:0]  s_total_n, s_seen_n, s_step_n, s_cnt_n;
	logic [4:0]  s_time_n, s_lim;
	logic [1:0]  s_rpt_n;
	logic [23:0] s_rgb_n;

	always_comb begin
		s_total_n = s_total_q;
		s_seen_n  = s_seen_q;
		s_step_n  = s_step_q;
		s_cnt_n   = s_cnt_q;
		s_time_n  = s_time_q;
		s_rpt_n   = s_rpt_q;
		s_hold_n  = s_hold_q;
		s_rgb_n   = star_rgb_q;
		s_trig    = (s_seen_q < s_total_q) ||
			((({1'b0, s_cnt_q} + {1'b0, smargin_q}) < {1'b0, s_total_q}) &&
			 (s_rpt_q < limit_q));
		if (s_trig) begin
			s_hold_n = 1'b1;
			s_rpt_n  = (s_seen_q == s_total_q) ? s_rpt_q + 2'd1 : 2'd0;
			s_seen_n = s_total_q;
			s_step_n = s_total_q;
			s_time_n = '0;
			s_rgb_n  = lbm_pkg::pal_rot(s_total_q);
			s_cnt_n  = s_total_q;
		end
		s_lim = lbm_pkg::HOLD_BASE - s_step_n[5:1];
		if (s_hold_n) begin
			if (s_time_n < s_lim) begin
				s_time_n = s_time_n + 5'd1;
			end else begin
				s_hold_n = 1'b0;
			end
		end else if (s_cnt_n != 6'd0) begin
			s_rgb_n = lbm_pkg::pal_rot(s_cnt_n);
			s_cnt_n = s_cnt_n - 6'd1;
		end else begin
			s_seen_n  = '0;
			s_total_n = '0;
			s_rgb_n   = '0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			lbm_pkg::TS_INIT: if (lanes_idle) state_d = lbm_pkg::TS_IDLE;
			lbm_pkg::TS_IDLE: begin
				if (acc) begin
					if (op == lbm_pkg::OP_READ) begin
						state_d = lbm_pkg::TS_READ;
					end else if (op == lbm_pkg::OP_START ||
						(op == lbm_pkg::OP_TICK && enabled_q)) begin
						state_d = lbm_pkg::TS_WAIT;
					end
				end
			end
			lbm_pkg::TS_WAIT: if (lanes_idle) state_d = lbm_pkg::TS_IDLE;
			lbm_pkg::TS_READ: state_d = lbm_pkg::TS_IDLE;
			default:          state_d = lbm_pkg::TS_IDLE;
		endcase
	end

	// result strobe and read data select
	logic        done_d;
	logic [23:0] rgb_d;

	always_comb begin
		done_d = 1'b0;
		rgb_d  = '0;
		case (state_q)
			lbm_pkg::TS_IDLE: begin
				done_d = acc && (op == lbm_pkg::OP_LOAD ||
					(op == lbm_pkg::OP_TICK && !enabled_q));
			end
			lbm_pkg::TS_WAIT: done_d = lanes_idle;
			lbm_pkg::TS_READ: begin
				done_d = 1'b1;
				if (rd_bar_q) begin
					rgb_d = lane_rd[rd_lane_q];
				end else if (rd_star_q) begin
					rgb_d = star_rgb_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= lbm_pkg::TS_INIT;
			active_q   <= 16'd250;
			period_q   <= 4'd2;
			bmargin_q  <= 4'd2;
			smargin_q  <= 6'd10;
			limit_q    <= 2'd2;
			enabled_q  <= 1'b0;
			etime_q    <= '0;
			s_total_q  <= '0;
			s_seen_q   <= '0;
			s_step_q   <= '0;
			s_cnt_q    <= '0;
			s_time_q   <= '0;
			s_rpt_q    <= '0;
			s_hold_q   <= 1'b0;
			star_rgb_q <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (cfg_we) begin
				case (cfg_index)
					lbm_pkg::CFG_ACTIVE_TICKS: active_q  <= cfg_data;
					lbm_pkg::CFG_FALL_PERIOD:  period_q  <= cfg_data[3:0];
					lbm_pkg::CFG_BAR_MARGIN:   bmargin_q <= cfg_data[3:0];
					lbm_pkg::CFG_STAR_MARGIN:  smargin_q <= cfg_data[5:0];
					lbm_pkg::CFG_RPT_LIMIT:    limit_q   <= cfg_data[1:0];
					default: ;
				endcase
			end
			if (acc) begin
				case (op)
					lbm_pkg::OP_LOAD: begin
						s_total_q <= (total_level > lbm_pkg::PAL_LAST) ?
							lbm_pkg::PAL_LAST : total_level;
					end
					lbm_pkg::OP_START: begin
						enabled_q  <= 1'b1;
						etime_q    <= '0;
						star_rgb_q <= '0;
					end
					lbm_pkg::OP_TICK: begin
						if (enabled_q) begin
							etime_q <= etime_inc;
							if (expire) begin
								enabled_q  <= 1'b0;
								star_rgb_q <= '0;
							end else begin
								s_total_q  <= s_total_n;
								s_seen_q   <= s_seen_n;
								s_step_q   <= s_step_n;
								s_cnt_q    <= s_cnt_n;
								s_time_q   <= s_time_n;
								s_rpt_q    <= s_rpt_n;
								s_hold_q   <= s_hold_n;
								star_rgb_q <= s_rgb_n;
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_bar_q  <= ({1'b0, group_index} < 4'(lbm_pkg::BAR_COUNT)) &&
				({1'b0, led_index} < 7'(lbm_pkg::LEDS_PER_BAR));
			rd_star_q <= ({1'b0, group_index} == 4'(lbm_pkg::BAR_COUNT)) &&
				({1'b0, led_index} < 7'(lbm_pkg::STAR_LEDS));
			rd_lane_q <= group_index[lbm_pkg::LANE_W-1:0];
		end
		if (done_d) begin
			rgb_q <= rgb_d;
		end
	end

	assign busy       = state_q != lbm_pkg::TS_IDLE;
	assign done       = done_q;
	assign red_duty   = rgb_q[23:16];
	assign green_duty = rgb_q[15:8];
	assign blue_duty  = rgb_q[7:0];
	assign running    = enabled_q;
endmodule
`default_nettype wire

// File: sv/lbm_checker.sv
`default_nettype none
`include "assert_macros.svh"
module lbm_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic running
);
	// every accepted request shows either work in flight or its result
	`AST_NEXT(a_acc_progress, clk, arst_n, start && !busy, busy || done)
	// the result strobe only appears once the block is free again
	`AST_IMPL(a_done_idle, clk, arst_n, done, !busy)
	// running only changes as a request is taken
	`AST_IMPL(a_run_rise, clk, arst_n, $rose(running), $past(start && !busy))
	`AST_IMPL(a_run_fall, clk, arst_n, $fell(running), $past(start && !busy))
endmodule

bind led_bar_meter_peak_fall_unit lbm_checker u_lbm_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.running (running)
);
`default_nettype wire
